// ----- sv/mips_subset_instruction_executor_macros.svh -----
// Assertion macros shared by the checker.
// No dependencies.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH

// implication checked outside reset
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define MSE_ASSERT_POST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mse_pkg.sv -----
// Shared types, constants and helpers of the instruction executor.
// No dependencies.
package mse_pkg;

   localparam int DATA_BYTES = 1024;
   localparam int DM_AW      = $clog2(DATA_BYTES);
   localparam int BANK_DEPTH = DATA_BYTES / 4;
   localparam int BANK_AW    = DM_AW - 2;

   localparam logic [1:0] CMD_EXEC    = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic CSR_START_PC = 1'b0;
   localparam logic CSR_START_SP = 1'b1;

   localparam logic [4:0] SP_REG = 5'd29;
   localparam logic [4:0] RA_REG = 5'd31;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_NORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_HALT    = 6'h3F;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_NAND = 6'h28;
   localparam logic [5:0] FN_SLT  = 6'h2A;

   localparam logic [2:0] SZ_NONE = 3'd0;
   localparam logic [2:0] SZ_BYTE = 3'd1;
   localparam logic [2:0] SZ_HALF = 3'd2;
   localparam logic [2:0] SZ_WORD = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] instr_raw;
      logic [9:0]  load_address;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        err_write_zero;
      logic        err_overflow;
      logic        err_address;
      logic        err_misaligned;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        store_written;
      logic [9:0]  store_address;
   } rsp_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [31:0] val;
   } rf_wr_type;

   typedef struct packed {
      logic               en;
      logic [3:0]         be;
      logic [BANK_AW-1:0] idx;
      logic [31:0]        data;
   } dm_wr_type;

   typedef struct packed {
      rsp_type            rsp;
      logic [31:0]        pc_in;
      logic               halt_in;
      rf_wr_type          rf_wr;
      dm_wr_type          dm_wr;
      logic               ld_start;
      logic [BANK_AW-1:0] ld_idx;
      logic [1:0]         ld_lo;
      logic [2:0]         ld_size;
      logic               ld_sgn;
      logic [4:0]         ld_rt;
   } exec_type;

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic add_ovf(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      return (a[31] == b[31]) && (s[31] != a[31]);
   endfunction

   // big-endian lanes: lane k sits at w[31-8k -: 8]
   function automatic logic [31:0] load_format(input logic [31:0] w, input logic [1:0] lo,
                                               input logic [2:0] size, input logic sgn);
      logic [15:0] h;
      logic [7:0]  b;
      h = lo[1] ? w[15:0] : w[31:16];
      b = w[8*(3-lo) +: 8];
      if (size == SZ_WORD) return w;
      else if (size == SZ_HALF) return {{16{sgn & h[15]}}, h};
      else return {{24{sgn & b[7]}}, b};
   endfunction

endpackage

// ----- sv/mips_subset_instruction_executor.sv -----
// Top level of the instruction executor: input stage, execute, output register.
// Depends on mse_pkg, mse_regfile, mse_dmem, mse_exec.
//
//   channel   ports                          moves
//   req       req_valid/req_ready/req_word   one command word in
//   rsp       rsp_valid/rsp_ready/rsp_word   one result word out
//   csr       csr_wr_en/csr_index/csr_wdata  start_pc, start_sp writes
//
// One word per cycle while rsp is not stalled; a load with a nonzero target
// holds back the next word until its registered data-memory read returns.
// Operands come from the register file read the cycle before, with the last
// write forwarded. After reset the data memory runs a clearing pass over all
// DATA_BYTES/4 (256) words with req_ready low. A stalled rsp holds its word;
// req still fills the input stage.
module mips_subset_instruction_executor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mse_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mse_pkg::rsp_type  rsp_word,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import mse_pkg::*;

   req_type            s1_ff;
   logic               s1_vld_ff;
   logic [31:0]        pc_ff, start_pc_ff, start_sp_ff;
   logic               halt_ff;
   logic               pend_ff;
   rsp_type            pend_rsp_ff;
   logic [BANK_AW-1:0] pend_idx_ff;
   logic [1:0]         pend_lo_ff;
   logic [2:0]         pend_size_ff;
   logic               pend_sgn_ff;
   logic [4:0]         pend_rt_ff;
   logic               rsp_vld_ff;
   rsp_type            rsp_ff, rsp_in;

   logic        out_free, fire, pend_done, accept, dm_busy;
   logic [31:0] req_ins, s1_ins, rs_val, rt_val, dm_rdata, ld_val;
   logic [4:0]  ra, rb;
   exec_type    ex;
   rf_wr_type   rf_wr;
   dm_wr_type   dm_wr;

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign fire      = s1_vld_ff && !pend_ff && out_free;
   assign pend_done = pend_ff && out_free;
   assign req_ready = !dm_busy && (!s1_vld_ff || fire);
   assign accept    = req_valid && req_ready;

   assign req_ins = swap32(req_word.instr_raw);
   assign s1_ins  = swap32(s1_ff.instr_raw);
   assign ra      = accept ? req_ins[25:21] : s1_ins[25:21];
   assign rb      = accept ? req_ins[20:16] : s1_ins[20:16];

   mse_regfile u_rf (
      .clock (clock),
      .reset (reset),
      .ra    (ra),
      .rb    (rb),
      .wr    (rf_wr),
      .a_val (rs_val),
      .b_val (rt_val)
   );

   mse_exec u_exec (
      .item     (s1_ff),
      .rs_val   (rs_val),
      .rt_val   (rt_val),
      .pc       (pc_ff),
      .halt     (halt_ff),
      .start_pc (start_pc_ff),
      .start_sp (start_sp_ff),
      .res      (ex)
   );

   mse_dmem u_dm (
      .clock   (clock),
      .reset   (reset),
      .wr      (dm_wr),
      .rd_idx  (pend_ff ? pend_idx_ff : ex.ld_idx),
      .rd_data (dm_rdata),
      .busy    (dm_busy)
   );

   always_comb begin
      ld_val = load_format(dm_rdata, pend_lo_ff, pend_size_ff, pend_sgn_ff);
      rf_wr  = '0;
      dm_wr  = '0;
      rsp_in = ex.rsp;
      if (pend_done) begin
         rf_wr.en  = 1'b1;
         rf_wr.idx = pend_rt_ff;
         rf_wr.val = ld_val;
         rsp_in             = pend_rsp_ff;
         rsp_in.reg_written = 1'b1;
         rsp_in.reg_index   = pend_rt_ff;
         rsp_in.reg_value   = ld_val;
      end else if (fire) begin
         rf_wr = ex.rf_wr;
         dm_wr = ex.dm_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         start_pc_ff <= '0;
         start_sp_ff <= '0;
      end else begin
         if (accept) s1_vld_ff <= 1'b1;
         else if (fire) s1_vld_ff <= 1'b0;
         if (fire) begin
            pc_ff   <= ex.pc_in;
            halt_ff <= ex.halt_in;
         end
         if (fire && ex.ld_start) pend_ff <= 1'b1;
         else if (pend_done) pend_ff <= 1'b0;
         if ((fire && !ex.ld_start) || pend_done) rsp_vld_ff <= 1'b1;
         else if (rsp_ready) rsp_vld_ff <= 1'b0;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_PC: start_pc_ff <= csr_wdata;
               CSR_START_SP: start_sp_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= req_word;
      if (fire && ex.ld_start) begin
         pend_rsp_ff  <= ex.rsp;
         pend_idx_ff  <= ex.ld_idx;
         pend_lo_ff   <= ex.ld_lo;
         pend_size_ff <= ex.ld_size;
         pend_sgn_ff  <= ex.ld_sgn;
         pend_rt_ff   <= ex.ld_rt;
      end
      if ((fire && !ex.ld_start) || pend_done) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- sv/mse_regfile.sv -----
// Register file: 32x32 memory, two registered read ports, one write port.
// Valid bits give zero after reset; the write of the read edge is forwarded.
module mse_regfile (
   input  logic                clock,
   input  logic                reset,
   input  logic [4:0]          ra,
   input  logic [4:0]          rb,
   input  mse_pkg::rf_wr_type  wr,
   output logic [31:0]         a_val,
   output logic [31:0]         b_val
);
   import mse_pkg::*;

   logic [31:0] mem [32];
   logic [31:0] vld_ff;
   logic [31:0] a_q_ff, b_q_ff;
   logic [4:0]  ra_ff, rb_ff;
   rf_wr_type   wr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.idx] <= wr.val;
      a_q_ff <= vld_ff[ra] ? mem[ra] : 32'd0;
      b_q_ff <= vld_ff[rb] ? mem[rb] : 32'd0;
      ra_ff  <= ra;
      rb_ff  <= rb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         wr_ff.en <= 1'b0;
      end else begin
         if (wr.en) vld_ff[wr.idx] <= 1'b1;
         wr_ff.en <= wr.en;
      end
      wr_ff.idx <= wr.idx;
      wr_ff.val <= wr.val;
   end

   assign a_val = (wr_ff.en && wr_ff.idx == ra_ff) ? wr_ff.val : a_q_ff;
   assign b_val = (wr_ff.en && wr_ff.idx == rb_ff) ? wr_ff.val : b_q_ff;

endmodule

// ----- sv/mse_dmem.sv -----
// Data memory: four byte-lane banks, big-endian lanes, registered read.
// Zero-clearing pass over all BANK_DEPTH words after reset.
module mse_dmem (
   input  logic                         clock,
   input  logic                         reset,
   input  mse_pkg::dm_wr_type           wr,
   input  logic [mse_pkg::BANK_AW-1:0]  rd_idx,
   output logic [31:0]                  rd_data,
   output logic                         busy
);
   import mse_pkg::*;

   logic [7:0]         bank [4][BANK_DEPTH];
   logic [BANK_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic               busy_ff, busy_in;
   logic [31:0]        rd_ff;
   logic [3:0]         we;
   logic [BANK_AW-1:0] widx;
   logic [31:0]        wdata;

   always_comb begin
      clr_cnt_in = clr_cnt_ff + 1'b1;
      busy_in    = busy_ff && (clr_cnt_ff != BANK_AW'(BANK_DEPTH - 1));
      we         = busy_ff ? 4'b1111 : (wr.en ? wr.be : 4'b0000);
      widx       = busy_ff ? clr_cnt_ff : wr.idx;
      wdata      = busy_ff ? 32'd0 : wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (we[k]) bank[k][widx] <= wdata[8*(3-k) +: 8];
         rd_ff[8*(3-k) +: 8] <= bank[k][rd_idx];
      end
   end

   assign rd_data = rd_ff;
   assign busy    = busy_ff;

endmodule

// ----- sv/mse_exec.sv -----
// Execute logic: decode, ALU, branch, address and error checks for one word.
// Depends on mse_pkg.
module mse_exec (
   input  mse_pkg::req_type   item,
   input  logic [31:0]        rs_val,
   input  logic [31:0]        rt_val,
   input  logic [31:0]        pc,
   input  logic               halt,
   input  logic [31:0]        start_pc,
   input  logic [31:0]        start_sp,
   output mse_pkg::exec_type  res
);
   import mse_pkg::*;

   logic [31:0] ins, simm, val, off, addr, pc4, la_ext;
   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sh, dest;
   logic [2:0]  size;
   logic [32:0] end_sum;
   logic        is_load, sgn, has_dest, ovf, ewz, ead, emis;

   always_comb begin
      ins      = swap32(item.instr_raw);
      op       = ins[31:26];
      rt       = ins[20:16];
      rd       = ins[15:11];
      sh       = ins[10:6];
      fn       = ins[5:0];
      simm     = {{16{ins[15]}}, ins[15:0]};
      off      = {simm[29:0], 2'b00};
      pc4      = pc + 32'd4;
      la_ext   = {22'd0, item.load_address};
      addr     = rs_val + simm;
      val      = '0;
      dest     = '0;
      has_dest = 1'b0;
      size     = SZ_NONE;
      is_load  = 1'b0;
      sgn      = 1'b0;
      ovf      = 1'b0;
      ewz      = 1'b0;
      ead      = 1'b0;
      emis     = 1'b0;
      end_sum  = '0;
      res      = '0;
      res.pc_in   = pc;
      res.halt_in = halt;

      unique case (item.cmd)
         CMD_EXEC: begin
            if (!halt) begin
               res.pc_in = pc4;
               unique case (op)
                  OP_SPECIAL: begin
                     has_dest = 1'b1;
                     dest     = rd;
                     unique case (fn)
                        FN_ADD: begin
                           val = rs_val + rt_val;
                           ovf = add_ovf(rs_val, rt_val);
                        end
                        FN_SUB: begin
                           val = rs_val - rt_val;
                           ovf = (rs_val[31] ^ rt_val[31]) & (rs_val[31] ^ val[31]);
                        end
                        FN_AND:  val = rs_val & rt_val;
                        FN_OR:   val = rs_val | rt_val;
                        FN_XOR:  val = rs_val ^ rt_val;
                        FN_NOR:  val = ~(rs_val | rt_val);
                        FN_NAND: val = ~(rs_val & rt_val);
                        FN_SLT:  val = {31'd0, $signed(rs_val) < $signed(rt_val)};
                        FN_SLL: begin
                           val      = rt_val << sh;
                           has_dest = (ins != 32'd0);
                        end
                        FN_SRL:  val = rt_val >> sh;
                        FN_SRA:  val = $unsigned($signed(rt_val) >>> sh);
                        FN_JR: begin
                           has_dest  = 1'b0;
                           res.pc_in = rs_val;
                        end
                        default: has_dest = 1'b0;
                     endcase
                  end
                  OP_J:   res.pc_in = {pc4[31:28], ins[25:0], 2'b00};
                  OP_JAL: begin
                     val       = pc4;
                     has_dest  = 1'b1;
                     dest      = RA_REG;
                     res.pc_in = {pc4[31:28], ins[25:0], 2'b00};
                  end
                  OP_HALT: res.halt_in = 1'b1;
                  OP_ADDI: begin
                     val      = rs_val + simm;
                     ovf      = add_ovf(rs_val, simm);
                     has_dest = 1'b1;
                     dest     = rt;
                  end
                  OP_LUI: begin
                     val = {ins[15:0], 16'd0}; has_dest = 1'b1; dest = rt;
                  end
                  OP_ANDI: begin
                     val = rs_val & {16'd0, ins[15:0]}; has_dest = 1'b1; dest = rt;
                  end
                  OP_ORI: begin
                     val = rs_val | {16'd0, ins[15:0]}; has_dest = 1'b1; dest = rt;
                  end
                  OP_NORI: begin
                     val = ~(rs_val | {16'd0, ins[15:0]}); has_dest = 1'b1; dest = rt;
                  end
                  OP_SLTI: begin
                     val = {31'd0, $signed(rs_val) < $signed(simm)};
                     has_dest = 1'b1;
                     dest = rt;
                  end
                  OP_BEQ, OP_BNE: begin
                     ovf = add_ovf(pc4, off);
                     if ((op == OP_BEQ) == (rs_val == rt_val)) res.pc_in = pc4 + off;
                  end
                  OP_LW:  begin size = SZ_WORD; is_load = 1'b1; end
                  OP_LH:  begin size = SZ_HALF; is_load = 1'b1; sgn = 1'b1; end
                  OP_LHU: begin size = SZ_HALF; is_load = 1'b1; end
                  OP_LB:  begin size = SZ_BYTE; is_load = 1'b1; sgn = 1'b1; end
                  OP_LBU: begin size = SZ_BYTE; is_load = 1'b1; end
                  OP_SW:  size = SZ_WORD;
                  OP_SH:  size = SZ_HALF;
                  OP_SB:  size = SZ_BYTE;
                  default: ;
               endcase

               end_sum = {1'b0, addr} + {30'd0, size};
               if (size != SZ_NONE) begin
                  ovf  = add_ovf(rs_val, simm);
                  ewz  = is_load && (rt == 5'd0);
                  ead  = (addr >= 32'(DATA_BYTES)) || (end_sum > 33'(DATA_BYTES));
                  emis = ((size == SZ_WORD) && (addr[1:0] != 2'b00)) ||
                         ((size == SZ_HALF) && addr[0]);
                  res.ld_idx  = addr[DM_AW-1:2];
                  res.ld_lo   = addr[1:0];
                  res.ld_size = size;
                  res.ld_sgn  = sgn;
                  res.ld_rt   = rt;
                  if (ead || emis) begin
                     res.halt_in = 1'b1;
                  end else if (is_load) begin
                     res.ld_start = (rt != 5'd0);
                  end else begin
                     res.dm_wr.en  = 1'b1;
                     res.dm_wr.idx = addr[DM_AW-1:2];
                     priority if (size == SZ_WORD) begin
                        res.dm_wr.be   = 4'b1111;
                        res.dm_wr.data = rt_val;
                     end else if (size == SZ_HALF) begin
                        res.dm_wr.be   = addr[1] ? 4'b1100 : 4'b0011;
                        res.dm_wr.data = {rt_val[15:0], rt_val[15:0]};
                     end else begin
                        res.dm_wr.be   = 4'b0001 << addr[1:0];
                        res.dm_wr.data = {4{rt_val[7:0]}};
                     end
                     res.rsp.store_written = 1'b1;
                     res.rsp.store_address = addr[9:0];
                  end
               end

               if (has_dest) begin
                  if (dest == 5'd0) begin
                     ewz = 1'b1;
                  end else begin
                     res.rf_wr.en  = 1'b1;
                     res.rf_wr.idx = dest;
                     res.rf_wr.val = val;
                     res.rsp.reg_written = 1'b1;
                     res.rsp.reg_index   = dest;
                     res.rsp.reg_value   = val;
                  end
               end
            end
         end
         CMD_BYTE: begin
            if (la_ext < 32'(DATA_BYTES)) begin
               res.dm_wr.en   = 1'b1;
               res.dm_wr.idx  = la_ext[DM_AW-1:2];
               res.dm_wr.be   = 4'b0001 << item.load_address[1:0];
               res.dm_wr.data = {4{item.load_byte}};
            end
         end
         CMD_RESTART: begin
            res.pc_in     = start_pc;
            res.halt_in   = 1'b0;
            res.rf_wr.en  = 1'b1;
            res.rf_wr.idx = SP_REG;
            res.rf_wr.val = start_sp;
         end
         CMD_NONE: ;
      endcase

      res.rsp.next_pc        = res.pc_in;
      res.rsp.halted         = res.halt_in;
      res.rsp.err_write_zero = ewz;
      res.rsp.err_overflow   = ovf;
      res.rsp.err_address    = ead;
      res.rsp.err_misaligned = emis;
   end

endmodule

// ----- sv/mse_checker.sv -----
// Port-level checker for the instruction executor, bound to the top level.
// Depends on mse_pkg and the assertion macro header.
`include "mips_subset_instruction_executor_macros.svh"

module mse_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mse_pkg::rsp_type  rsp_word
);
   import mse_pkg::*;

   `MSE_ASSERT_POST(a_clear_after_reset, reset, !req_ready, "req_ready high during clearing pass")
   `MSE_ASSERT_IMP(a_rsp_hold, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_word)), "stalled rsp word changed")
   `MSE_ASSERT_IMP(a_one_write, rsp_valid, !(rsp_word.store_written && rsp_word.reg_written), "store and register write in one word")
   `MSE_ASSERT_IMP(a_addr_halts, rsp_valid && rsp_word.err_address, rsp_word.halted && !rsp_word.store_written, "address error without halt")
   `MSE_ASSERT_IMP(a_mis_halts, rsp_valid && rsp_word.err_misaligned, rsp_word.halted && !rsp_word.reg_written, "misalignment without halt")

endmodule

bind mips_subset_instruction_executor mse_checker u_mse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
